### rtl/nrcp_pkg.sv
package nrcp_pkg;

  localparam int NUM_REGIONS_DEF = 64;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int ID_W            = 6;
  localparam int TIME_W          = 64;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_END   = 2'd1,
    REQ_RREG  = 2'd2,
    REQ_RLINK = 2'd3
  } req_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Region numbers are already reduced modulo the region count here.
  typedef struct packed {
    req_t                req;
    logic [ID_W-1:0]     rid;
    logic [ID_W-1:0]     cid;
    logic [TIME_W-1:0]   t_stop;
    logic [TIME_W-1:0]   t_resume;
  } item_t;

endpackage

### rtl/nrcp_front.sv
module nrcp_front #(
  parameter int NUM_REGIONS = nrcp_pkg::NUM_REGIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_req_type,
  input  logic [nrcp_pkg::ID_W-1:0]         in_region_id,
  input  logic [nrcp_pkg::ID_W-1:0]         in_caller_id,
  input  logic [nrcp_pkg::TIME_W-1:0]       in_suspend_time,
  input  logic [nrcp_pkg::TIME_W-1:0]       in_resume_time,
  input  logic                              clearing,
  output logic                              q_valid,
  input  logic                              q_pop,
  output nrcp_pkg::item_t                   q_item
);

  localparam int ID_N = 1 << nrcp_pkg::ID_W;

  // Reduction modulo the region count as a constant lookup.
  function automatic logic [nrcp_pkg::ID_W-1:0] id_mod(input logic [nrcp_pkg::ID_W-1:0] v);
    logic [nrcp_pkg::ID_W-1:0] r;
    r = '0;
    for (int i = 0; i < ID_N; i++) begin
      if (v == nrcp_pkg::ID_W'(i)) r = nrcp_pkg::ID_W'(i % NUM_REGIONS);
    end
    return r;
  endfunction

  nrcp_pkg::item_t q_mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  nrcp_pkg::item_t item_in;

  assign in_stall = (cnt_r == 2'd2) || clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rp_r];

  always_comb begin
    item_in.req      = nrcp_pkg::req_t'(in_req_type);
    item_in.rid      = id_mod(in_region_id);
    item_in.cid      = id_mod(in_caller_id);
    item_in.t_stop   = in_suspend_time;
    item_in.t_resume = in_resume_time;
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      if (push && !q_pop) cnt_r <= cnt_r + 2'd1;
      else if (q_pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

### rtl/nrcp_back.sv
module nrcp_back #(
  parameter int NUM_REGIONS = nrcp_pkg::NUM_REGIONS_DEF,
  parameter int STACK_DEPTH = nrcp_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  nrcp_pkg::item_t              q_item,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic                         out_had_parent,
  output logic [63:0]                  out_self_ticks,
  output logic [63:0]                  out_region_calls,
  output logic [63:0]                  out_children_ticks,
  output logic [63:0]                  out_link_calls,
  output logic [63:0]                  out_link_child_ticks,
  output logic [63:0]                  out_link_grandchild_ticks
);

  localparam int RB = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int LD = NUM_REGIONS * NUM_REGIONS;
  localparam int LB = $clog2(LD);
  localparam int SB = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CB = $clog2(STACK_DEPTH + 1);
  localparam int TW = nrcp_pkg::TIME_W;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CALC, S_PUSH, S_MRD, S_UPD, S_RES} state_t;

  state_t state_r;
  nrcp_pkg::item_t it_r;
  logic [CB-1:0] cnt_r;
  logic          clr_r;
  logic [LB-1:0] clr_cnt_r;
  logic [TW-1:0] self_r, kids_r, sum_r, bkids_r;
  logic [RB-1:0] child_r, preg_r;
  logic          par_ok_r;

  logic          out_valid_r, had_parent_r;
  logic [1:0]    status_r;
  logic [TW-1:0] o_self_r, o_calls_r, o_kids_r, o_lc_r, o_ls_r, o_ld_r;

  // Stack of active runs.
  logic [RB-1:0] st_reg  [STACK_DEPTH];
  logic [TW-1:0] st_self [STACK_DEPTH];
  logic [TW-1:0] st_kids [STACK_DEPTH];
  logic [TW-1:0] st_last [STACK_DEPTH];
  logic [RB-1:0] a_reg, b_reg;
  logic [TW-1:0] a_self, a_kids, a_last, b_kids;
  logic [SB-1:0] top_idx, par_idx, push_idx;

  // Per-region totals and per-link counters.
  logic [TW-1:0] rg_self  [NUM_REGIONS];
  logic [TW-1:0] rg_calls [NUM_REGIONS];
  logic [TW-1:0] rg_tot   [NUM_REGIONS];
  logic [TW-1:0] lk_calls [LD];
  logic [TW-1:0] lk_self  [LD];
  logic [TW-1:0] lk_desc  [LD];
  logic [TW-1:0] rs_q, rc_q, rt_q, lc_q, ls_q, ld_q;

  logic          is_end;
  logic [RB-1:0] ra_addr, rb_addr, lk_hi, lk_lo;
  logic [LB-1:0] lk_addr;
  logic          upd_par;
  logic [RB-1:0] rw_a, rw_b;
  logic [LB-1:0] lw_addr;
  logic          rw_self_en, rw_par_en, lw_en;
  logic [TW-1:0] rw_self_d, rw_calls_d, rw_tot_d, lw_calls_d, lw_self_d, lw_desc_d;
  logic [TW-1:0] paused;

  assign clearing = clr_r;
  assign q_pop    = (state_r == S_IDLE) && !clr_r && q_valid && !out_valid_r;

  assign top_idx  = SB'(cnt_r - CB'(1));
  assign par_idx  = SB'(cnt_r - CB'(2));
  assign push_idx = SB'(cnt_r);

  assign is_end  = (it_r.req == nrcp_pkg::REQ_END);
  assign ra_addr = is_end ? child_r : RB'(it_r.rid);
  assign rb_addr = is_end ? preg_r : RB'(it_r.rid);
  assign lk_hi   = is_end ? preg_r : RB'(it_r.cid);
  assign lk_lo   = is_end ? child_r : RB'(it_r.rid);
  assign lk_addr = LB'(lk_hi * NUM_REGIONS) + LB'(lk_lo);

  // Pause the run on the stack top: elapsed time counts only when positive.
  assign paused = (a_last < it_r.t_stop) ? a_self + (it_r.t_stop - a_last) : a_self;

  assign upd_par = (state_r == S_UPD) && par_ok_r;

  always_comb begin
    if (clr_r) begin
      rw_a       = clr_cnt_r[RB-1:0];
      rw_b       = clr_cnt_r[RB-1:0];
      lw_addr    = clr_cnt_r;
      rw_self_en = 1'b1;
      rw_par_en  = 1'b1;
      lw_en      = 1'b1;
      rw_self_d  = '0;
      rw_calls_d = '0;
      rw_tot_d   = '0;
      lw_calls_d = '0;
      lw_self_d  = '0;
      lw_desc_d  = '0;
    end else begin
      rw_a       = child_r;
      rw_b       = preg_r;
      lw_addr    = lk_addr;
      rw_self_en = (state_r == S_UPD);
      rw_par_en  = upd_par;
      lw_en      = upd_par;
      rw_self_d  = rs_q + self_r;
      rw_calls_d = rc_q + TW'(1);
      rw_tot_d   = rt_q + sum_r;
      lw_calls_d = lc_q + TW'(1);
      lw_self_d  = ls_q + self_r;
      lw_desc_d  = ld_q + kids_r;
    end
  end

  always_ff @(posedge clk) begin
    a_reg  <= st_reg[top_idx];
    a_self <= st_self[top_idx];
    a_kids <= st_kids[top_idx];
    a_last <= st_last[top_idx];
    b_reg  <= st_reg[par_idx];
    b_kids <= st_kids[par_idx];
    if (state_r == S_CALC && it_r.req == nrcp_pkg::REQ_BEGIN) st_self[top_idx] <= paused;
    if (state_r == S_PUSH) begin
      st_reg[push_idx]  <= RB'(it_r.rid);
      st_self[push_idx] <= '0;
      st_kids[push_idx] <= '0;
      st_last[push_idx] <= it_r.t_resume;
    end
    if (upd_par) begin
      st_kids[par_idx] <= bkids_r + sum_r;
      st_last[par_idx] <= it_r.t_resume;
    end
  end

  always_ff @(posedge clk) begin
    rs_q <= rg_self[ra_addr];
    rc_q <= rg_calls[ra_addr];
    rt_q <= rg_tot[rb_addr];
    if (rw_self_en) rg_self[rw_a] <= rw_self_d;
    if (rw_par_en) begin
      rg_calls[rw_a] <= rw_calls_d;
      rg_tot[rw_b]   <= rw_tot_d;
    end
  end

  always_ff @(posedge clk) begin
    lc_q <= lk_calls[lk_addr];
    ls_q <= lk_self[lk_addr];
    ld_q <= lk_desc[lk_addr];
    if (lw_en) begin
      lk_calls[lw_addr] <= lw_calls_d;
      lk_self[lw_addr]  <= lw_self_d;
      lk_desc[lw_addr]  <= lw_desc_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + LB'(1);
        if (clr_cnt_r == LB'(LD - 1)) clr_r <= 1'b0;
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            it_r         <= q_item;
            status_r     <= nrcp_pkg::ST_OK;
            had_parent_r <= 1'b0;
            o_self_r     <= '0;
            o_calls_r    <= '0;
            o_kids_r     <= '0;
            o_lc_r       <= '0;
            o_ls_r       <= '0;
            o_ld_r       <= '0;
            par_ok_r     <= (cnt_r >= CB'(2));
            case (q_item.req)
              nrcp_pkg::REQ_BEGIN: begin
                if (cnt_r >= CB'(STACK_DEPTH)) begin
                  status_r    <= nrcp_pkg::ST_OVF;
                  out_valid_r <= 1'b1;
                end else if (cnt_r == '0) begin
                  state_r <= S_PUSH;
                end else begin
                  state_r <= S_RD;
                end
              end
              nrcp_pkg::REQ_END: begin
                if (cnt_r == '0) begin
                  status_r    <= nrcp_pkg::ST_EMPTY;
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= S_RD;
                end
              end
              default: state_r <= S_MRD;
            endcase
          end
        end
        S_RD: state_r <= S_CALC;
        S_CALC: begin
          self_r  <= paused;
          kids_r  <= a_kids;
          child_r <= a_reg;
          preg_r  <= b_reg;
          bkids_r <= b_kids;
          state_r <= is_end ? S_MRD : S_PUSH;
        end
        S_PUSH: begin
          cnt_r       <= cnt_r + CB'(1);
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_MRD: begin
          sum_r   <= self_r + kids_r;
          state_r <= is_end ? S_UPD : S_RES;
        end
        S_UPD: begin
          cnt_r        <= cnt_r - CB'(1);
          had_parent_r <= par_ok_r;
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        S_RES: begin
          if (it_r.req == nrcp_pkg::REQ_RREG) begin
            o_self_r  <= rs_q;
            o_calls_r <= (rc_q != '0) ? rc_q : TW'(1);
            o_kids_r  <= rt_q;
          end else begin
            o_lc_r <= lc_q;
            o_ls_r <= ls_q;
            o_ld_r <= ld_q;
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_status                = status_r;
  assign out_had_parent            = had_parent_r;
  assign out_self_ticks            = o_self_r;
  assign out_region_calls          = o_calls_r;
  assign out_children_ticks        = o_kids_r;
  assign out_link_calls            = o_lc_r;
  assign out_link_child_ticks      = o_ls_r;
  assign out_link_grandchild_ticks = o_ld_r;

`ifndef SYNTHESIS
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CB'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !out_valid_r && !clr_r) else $error("item taken while busy");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !out_valid_r) else $error("result pending during work");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |=> cnt_r == $past(cnt_r) - CB'(1)) else $error("end did not pop");
`endif

endmodule

### rtl/nested_region_cycle_profiler.sv
// Nested region profiler: begin, end and read requests each give one result.
// Items pass a two-entry queue to a sequencer over synchronous memories, which
// steps, as each request needs, through the stack-top read, the pause update
// and the region and link read-modify-write. After reset a clearing pass over
// all region and link entries zeroes all totals, during which no transaction
// is accepted.
module nested_region_cycle_profiler #(
  parameter int NUM_REGIONS = nrcp_pkg::NUM_REGIONS_DEF,
  parameter int STACK_DEPTH = nrcp_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_region_id,
  input  logic [5:0]  in_caller_id,
  input  logic [63:0] in_suspend_time,
  input  logic [63:0] in_resume_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_had_parent,
  output logic [63:0] out_self_ticks,
  output logic [63:0] out_region_calls,
  output logic [63:0] out_children_ticks,
  output logic [63:0] out_link_calls,
  output logic [63:0] out_link_child_ticks,
  output logic [63:0] out_link_grandchild_ticks
);

  logic            clearing, q_valid, q_pop;
  nrcp_pkg::item_t q_item;

  nrcp_front #(.NUM_REGIONS(NUM_REGIONS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_region_id, .in_caller_id,
    .in_suspend_time, .in_resume_time, .clearing, .q_valid, .q_pop, .q_item
  );

  nrcp_back #(.NUM_REGIONS(NUM_REGIONS), .STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item, .clearing, .out_valid, .out_stall,
    .out_status, .out_had_parent, .out_self_ticks, .out_region_calls,
    .out_children_ticks, .out_link_calls, .out_link_child_ticks,
    .out_link_grandchild_ticks
  );

endmodule

### test/tb_nested_region_cycle_profiler.sv
module tb_nested_region_cycle_profiler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REGIONS    = 64;
  localparam int DEPTH      = 16;
  localparam int IDLE_LIMIT = 30000;
  localparam int HOLD_LEN   = 400;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    logic [1:0]  status;
    logic        had_parent;
    logic [63:0] self_ticks;
    logic [63:0] region_calls;
    logic [63:0] children_ticks;
    logic [63:0] link_calls;
    logic [63:0] link_child_ticks;
    logic [63:0] link_grandchild_ticks;
  } profile_result_t;

  class region_profile_board;
    logic [5:0]  run_region[DEPTH];
    logic [63:0] run_self[DEPTH];
    logic [63:0] run_kids[DEPTH];
    logic [63:0] run_last[DEPTH];
    int unsigned depth;
    logic [63:0] tot_self[REGIONS];
    logic [63:0] tot_calls[REGIONS];
    logic [63:0] tot_kids[REGIONS];
    logic [63:0] edge_calls[REGIONS*REGIONS];
    logic [63:0] edge_self[REGIONS*REGIONS];
    logic [63:0] edge_desc[REGIONS*REGIONS];
    profile_result_t pending_results[$];
    int errors;
    int checked;
    int overflows;
    int underflows;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        run_region[i] = '0;
        run_self[i] = '0;
        run_kids[i] = '0;
        run_last[i] = '0;
      end
      for (int i = 0; i < REGIONS; i++) begin
        tot_self[i] = '0;
        tot_calls[i] = '0;
        tot_kids[i] = '0;
      end
      for (int i = 0; i < REGIONS*REGIONS; i++) begin
        edge_calls[i] = '0;
        edge_self[i] = '0;
        edge_desc[i] = '0;
      end
      depth = 0;
      errors = 0;
      checked = 0;
      overflows = 0;
      underflows = 0;
    endfunction

    function void pause(int unsigned slot, logic [63:0] stop);
      if (run_last[slot] < stop) run_self[slot] += stop - run_last[slot];
    endfunction

    function void note_input(nrcp_pkg::req_t r, logic [5:0] rid, logic [5:0] cid,
                             logic [63:0] ts, logic [63:0] tr);
      profile_result_t e;
      int unsigned top;
      int unsigned par;
      int unsigned li;
      logic [5:0] child;
      logic [63:0] s;
      logic [63:0] k;
      e = '{default: '0};
      e.status = nrcp_pkg::ST_OK;
      case (r)
        nrcp_pkg::REQ_BEGIN: begin
          if (depth >= DEPTH) begin
            e.status = nrcp_pkg::ST_OVF;
            overflows++;
          end else begin
            if (depth > 0) pause(depth - 1, ts);
            run_region[depth] = rid;
            run_self[depth] = '0;
            run_kids[depth] = '0;
            run_last[depth] = tr;
            depth++;
          end
        end
        nrcp_pkg::REQ_END: begin
          if (depth == 0) begin
            e.status = nrcp_pkg::ST_EMPTY;
            underflows++;
          end else begin
            top = depth - 1;
            pause(top, ts);
            child = run_region[top];
            s = run_self[top];
            k = run_kids[top];
            depth = top;
            tot_self[child] += s;
            if (top > 0) begin
              par = top - 1;
              li = run_region[par] * REGIONS + child;
              run_kids[par] += s + k;
              tot_kids[run_region[par]] += s + k;
              tot_calls[child] += 1;
              edge_calls[li] += 1;
              edge_self[li] += s;
              edge_desc[li] += k;
              run_last[par] = tr;
              e.had_parent = 1'b1;
            end
          end
        end
        nrcp_pkg::REQ_RREG: begin
          e.self_ticks = tot_self[rid];
          e.region_calls = (tot_calls[rid] != 0) ? tot_calls[rid] : 64'd1;
          e.children_ticks = tot_kids[rid];
        end
        default: begin
          li = cid * REGIONS + rid;
          e.link_calls = edge_calls[li];
          e.link_child_ticks = edge_self[li];
          e.link_grandchild_ticks = edge_desc[li];
        end
      endcase
      pending_results.insert(pending_results.size(), e);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch on result %0d: %s got %h expected %h", checked, field, got, want);
      errors++;
    endtask

    task check_result(profile_result_t got);
      profile_result_t e;
      if (pending_results.size() == 0) begin
        report("unexpected transaction, status", 64'(got.status), 64'd0);
        return;
      end
      e = pending_results.pop_front();
      if (got.status !== e.status) report("status", 64'(got.status), 64'(e.status));
      if (got.had_parent !== e.had_parent)
        report("had_parent", 64'(got.had_parent), 64'(e.had_parent));
      if (got.self_ticks !== e.self_ticks) report("self_ticks", got.self_ticks, e.self_ticks);
      if (got.region_calls !== e.region_calls)
        report("region_calls", got.region_calls, e.region_calls);
      if (got.children_ticks !== e.children_ticks)
        report("children_ticks", got.children_ticks, e.children_ticks);
      if (got.link_calls !== e.link_calls) report("link_calls", got.link_calls, e.link_calls);
      if (got.link_child_ticks !== e.link_child_ticks)
        report("link_child_ticks", got.link_child_ticks, e.link_child_ticks);
      if (got.link_grandchild_ticks !== e.link_grandchild_ticks)
        report("link_grandchild_ticks", got.link_grandchild_ticks, e.link_grandchild_ticks);
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [5:0]  in_region_id;
  logic [5:0]  in_caller_id;
  logic [63:0] in_suspend_time;
  logic [63:0] in_resume_time;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_had_parent;
  logic [63:0] out_self_ticks;
  logic [63:0] out_region_calls;
  logic [63:0] out_children_ticks;
  logic [63:0] out_link_calls;
  logic [63:0] out_link_child_ticks;
  logic [63:0] out_link_grandchild_ticks;

  region_profile_board board;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_go;
  logic [63:0] now_ticks;

  nested_region_cycle_profiler uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_region_id(in_region_id),
    .in_caller_id(in_caller_id), .in_suspend_time(in_suspend_time),
    .in_resume_time(in_resume_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_had_parent(out_had_parent),
    .out_self_ticks(out_self_ticks), .out_region_calls(out_region_calls),
    .out_children_ticks(out_children_ticks), .out_link_calls(out_link_calls),
    .out_link_child_ticks(out_link_child_ticks),
    .out_link_grandchild_ticks(out_link_grandchild_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one request and returns at the edge where it is taken.
  task automatic send_request(nrcp_pkg::req_t r, logic [5:0] rid, logic [5:0] cid,
                              logic [63:0] ts, logic [63:0] tr);
    if (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r;
    in_region_id <= rid;
    in_caller_id <= cid;
    in_suspend_time <= ts;
    in_resume_time <= tr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(r, rid, cid, ts, tr);
  endtask

  task automatic random_request();
    int pick;
    nrcp_pkg::req_t r;
    logic [5:0] rid;
    logic [5:0] cid;
    logic [63:0] ts;
    logic [63:0] tr;
    pick = $urandom_range(1, 100);
    if (pick <= 4) begin
      r = nrcp_pkg::req_t'($urandom_range(0, 3));
    end else if (board.depth >= DEPTH) begin
      r = (pick <= 12) ? nrcp_pkg::REQ_BEGIN : nrcp_pkg::REQ_END;
    end else if (pick <= 45) begin
      r = nrcp_pkg::REQ_BEGIN;
    end else if (pick <= 75) begin
      r = nrcp_pkg::REQ_END;
    end else begin
      r = (pick <= 87) ? nrcp_pkg::REQ_RREG : nrcp_pkg::REQ_RLINK;
    end
    // A small pool of regions makes links repeat often.
    rid = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
    cid = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
    pick = $urandom_range(1, 100);
    if (pick <= 8) begin
      ts = {$urandom, $urandom};
      tr = {$urandom, $urandom};
    end else if (pick <= 14) begin
      ts = now_ticks - $urandom_range(0, 300);
      tr = ts + $urandom_range(0, 20);
      now_ticks = tr;
    end else begin
      ts = now_ticks + $urandom_range(0, 500);
      tr = ts + $urandom_range(0, 60);
      now_ticks = tr;
    end
    send_request(r, rid, cid, ts, tr);
  endtask

  initial begin
    bit held;
    out_stall = 1'b1;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
      end
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(1, 100) <= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    profile_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status = out_status;
      got.had_parent = out_had_parent;
      got.self_ticks = out_self_ticks;
      got.region_calls = out_region_calls;
      got.children_ticks = out_children_ticks;
      got.link_calls = out_link_calls;
      got.link_child_ticks = out_link_child_ticks;
      got.link_grandchild_ticks = out_link_grandchild_ticks;
      board.check_result(got);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    board = new();
    hold_go = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = nrcp_pkg::REQ_BEGIN;
    in_region_id = '0;
    in_caller_id = '0;
    in_suspend_time = '0;
    in_resume_time = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    now_ticks = {$urandom, $urandom};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme fields, outermost and nested ends, empty stack, overflow.
    send_request(nrcp_pkg::REQ_BEGIN, 6'd63, 6'd0, '1, 64'd0);
    send_request(nrcp_pkg::REQ_BEGIN, 6'd0, 6'd63, '1, '1);
    send_request(nrcp_pkg::REQ_END, 6'd0, 6'd0, 64'd5, 64'd0);
    send_request(nrcp_pkg::REQ_END, 6'd0, 6'd0, '1, '1);
    send_request(nrcp_pkg::REQ_END, 6'd63, 6'd63, '1, '1);
    send_request(nrcp_pkg::REQ_RREG, 6'd63, 6'd0, '0, '0);
    send_request(nrcp_pkg::REQ_RREG, 6'd0, 6'd0, '1, '1);
    send_request(nrcp_pkg::REQ_RLINK, 6'd0, 6'd63, '0, '0);
    for (int i = 0; i < DEPTH + 1; i++)
      send_request(nrcp_pkg::REQ_BEGIN, 6'(i), 6'd0, 64'(100 * i), 64'(100 * i + 7));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 12 : 0;
      if (phase == 2) hold_go <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (board.pending_results.size() != 0) @(posedge clk);
        end
        random_request();
      end
    end
    in_valid <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("checked %0d results from %0d directed and %0d random requests",
             board.checked, 8 + DEPTH + 1, 3 * PHASE_ITEMS);
    $display("stack overflows %0d, empty-stack ends %0d, mismatches %0d",
             board.overflows, board.underflows, board.errors);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
